FILE: rtl/b64e_pkg.sv
// shared types, constants and the base64 alphabet lookup for the stream encoder
package b64e_pkg;

  // number of work entries held between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // byte position within a 3-byte group
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // ascii code of the padding character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // one output character slot: a 6-bit symbol index or padding
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } b64e_slot_t;

  // work entry for one input byte: up to four characters
  typedef struct packed {
    b64e_slot_t [3:0] slots;
    logic [1:0]       last_idx;
    logic             fin;
  } b64e_job_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64e_sym(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      c = 8'h41 + v8;
    end else if (v < 6'd52) begin
      c = 8'h61 + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'h30 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
// front part: accepts bytes, tracks group position and splits bits into symbols
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  b64e_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output b64e_pkg::b64e_job_t job
);
  import b64e_pkg::*;

  logic [1:0] group_position_r, group_position_nxt;
  logic [3:0] leftover_r, leftover_nxt;
  logic [7:0] b;
  logic       fin;

  assign b    = in_data.data_byte;
  assign fin  = in_data.final_byte;
  assign push = in_valid && !q_full;

  // classify the byte by its place in the group
  always_comb begin
    job                = '0;
    job.fin            = fin;
    group_position_nxt = group_position_r;
    leftover_nxt       = leftover_r;
    unique case (group_position_r)
      POS_SECOND: begin
        job.slots[0].idx   = {leftover_r[1:0], b[7:4]};
        leftover_nxt       = b[3:0];
        group_position_nxt = POS_THIRD;
        job.last_idx       = 2'd0;
        if (fin) begin
          job.slots[1].idx = {b[3:0], 2'b00};
          job.slots[2].pad = 1'b1;
          job.last_idx     = 2'd2;
        end
      end
      POS_THIRD: begin
        job.slots[0].idx   = {leftover_r, b[7:6]};
        job.slots[1].idx   = b[5:0];
        job.last_idx       = 2'd1;
        leftover_nxt       = 4'd0;
        group_position_nxt = POS_FIRST;
      end
      default: begin
        job.slots[0].idx   = b[7:2];
        leftover_nxt       = {2'b00, b[1:0]};
        group_position_nxt = POS_SECOND;
        job.last_idx       = 2'd0;
        if (fin) begin
          job.slots[1].idx = {b[1:0], 4'b0000};
          job.slots[2].pad = 1'b1;
          job.slots[3].pad = 1'b1;
          job.last_idx     = 2'd3;
        end
      end
    endcase
    if (fin) begin
      group_position_nxt = POS_FIRST;
      leftover_nxt       = 4'd0;
    end
  end

  // group state advances on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_position_r <= POS_FIRST;
      leftover_r       <= 4'd0;
    end else if (push) begin
      group_position_r <= group_position_nxt;
      leftover_r       <= leftover_nxt;
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
// short work queue between the front and back parts
module b64e_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64e_pkg::b64e_job_t push_job,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output b64e_pkg::b64e_job_t head_job
);
  import b64e_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  b64e_job_t        entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entries_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
// back part: steps through queued characters and drives the result register
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64e_pkg::b64e_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data
);
  import b64e_pkg::*;

  logic [1:0] k_r;
  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;
  logic       fire;
  logic       is_last;
  b64e_slot_t slot;

  assign fire    = head_valid && (!out_valid_r || !out_stall);
  assign is_last = (k_r == head_job.last_idx);
  assign pop     = fire && is_last;
  assign slot    = head_job.slots[k_r];

  // character for the current slot
  always_comb begin
    out_data_nxt.out_char    = slot.pad ? PAD_CHAR : b64e_sym(slot.idx);
    out_data_nxt.run_last    = is_last;
    out_data_nxt.message_end = is_last && head_job.fin;
  end

  // slot counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        k_r <= is_last ? 2'd0 : k_r + 2'd1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a partly sent entry stays at the head of the queue
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd0) |-> head_valid)
    else $error("slot counter advanced without a queued entry");

  // the counter never runs past the entry's last slot
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (k_r <= head_job.last_idx))
    else $error("slot counter beyond last character");

  // message end only on the last character of an input
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_data_nxt.message_end) |=> (out_data_r.run_last && k_r == 2'd0))
    else $error("message end without run end");

endmodule

FILE: rtl/base64_stream_encoder.sv
// top level of the streaming base64 encoder
// Streaming base64 encoder, standard alphabet with '=' padding. Each input
// transfer carries one byte and a flag for the last byte of a message; each
// result transfer carries one character, a flag on the last character caused
// by that byte, and a flag on the final character of the message. A byte
// yields 1, 1 or 2 characters at group positions one, two and three, and 4, 3
// or 2 characters when it ends the message. The character sequencer emits one
// character per cycle while a queued entry waits and out_stall is low. A
// two-entry queue lets the input side accept a byte every cycle while it has
// room, and the output register keeps a result steady while out_stall is high.
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data
);
  import b64e_pkg::*;

  logic      push, pop, q_full, head_valid;
  b64e_job_t push_job, head_job;

  assign in_stall = q_full;

  // byte intake and symbol split
  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (push),
    .job     (push_job)
  );

  // work queue
  b64e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // character output
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
